>>> hdl/mhtc_pkg.sv
package mhtc_pkg;

  localparam int FX_W     = 32;
  localparam int NUM_VARS = 5;

  typedef logic signed [FX_W-1:0] fx_t;

  typedef struct packed {
    logic ovf;
    fx_t  v;
  } fxr_t;

  localparam fx_t FX_MAX     = fx_t'(32'h7FFF_FFFF);
  localparam fx_t FX_MIN     = fx_t'(32'h8000_0000);
  localparam fx_t FX_ONE     = fx_t'(32'd65536);
  localparam fx_t FX_HUNDRED = fx_t'(32'd6553600);

  localparam logic CFG_DTDX = 1'b0;
  localparam logic CFG_MODE = 1'b1;

  localparam logic [1:0] MODE_MUSCL   = 2'd0;
  localparam logic [1:0] MODE_PLMDE   = 2'd1;
  localparam logic [1:0] MODE_COLELLA = 2'd2;

  // Divider: dividend magnitude is |a| * 2^16, quotient magnitude below 2^48
  localparam int DIV_NUM_W     = FX_W + 16;
  localparam int DIV_BITS_STEP = 2;
  localparam int DIV_STEPS     = DIV_NUM_W / DIV_BITS_STEP;
  localparam int DIV_LAT       = DIV_STEPS + 2;

  typedef struct packed {
    fx_t density;
    fx_t vel_normal;
    fx_t vel_trans;
    fx_t pressure;
    fx_t sound_speed;
    fx_t slope_density;
    fx_t slope_vel_normal;
    fx_t slope_vel_trans;
    fx_t slope_pressure;
    fx_t scalar_value;
    fx_t scalar_slope;
  } in_t;

  typedef struct packed {
    fx_t  right_density;
    fx_t  right_vel_normal;
    fx_t  right_vel_trans;
    fx_t  right_pressure;
    fx_t  right_scalar;
    fx_t  left_density;
    fx_t  left_vel_normal;
    fx_t  left_vel_trans;
    fx_t  left_pressure;
    fx_t  left_scalar;
    logic overflow_flag;
  } out_t;

  function automatic fxr_t fx_sat33(input logic signed [FX_W:0] s);
    fxr_t res;
    res.ovf = (s[FX_W] != s[FX_W-1]);
    if (!res.ovf) res.v = s[FX_W-1:0];
    else if (s[FX_W]) res.v = FX_MIN;
    else res.v = FX_MAX;
    return res;
  endfunction

  function automatic fxr_t fx_add(input fx_t a, input fx_t b);
    logic signed [FX_W:0] s;
    s = {a[FX_W-1], a} + {b[FX_W-1], b};
    return fx_sat33(s);
  endfunction

  function automatic fxr_t fx_sub(input fx_t a, input fx_t b);
    logic signed [FX_W:0] s;
    s = {a[FX_W-1], a} - {b[FX_W-1], b};
    return fx_sat33(s);
  endfunction

  // Product shifted right by 16 with rounding toward minus infinity
  function automatic fxr_t fx_mul(input fx_t a, input fx_t b);
    logic signed [2*FX_W-1:0] ae;
    logic signed [2*FX_W-1:0] be;
    logic signed [2*FX_W-1:0] sh;
    fxr_t res;
    ae = a;
    be = b;
    sh = (ae * be) >>> 16;
    res.ovf = !((&sh[2*FX_W-1:FX_W-1]) || !(|sh[2*FX_W-1:FX_W-1]));
    if (!res.ovf) res.v = sh[FX_W-1:0];
    else if (sh[2*FX_W-1]) res.v = FX_MIN;
    else res.v = FX_MAX;
    return res;
  endfunction

  // Multiply by one half: cannot saturate
  function automatic fx_t fx_half(input fx_t a);
    return a >>> 1;
  endfunction

  // Multiply by minus one half: cannot saturate
  function automatic fx_t fx_negh(input fx_t a);
    logic signed [FX_W:0] n;
    n = -{a[FX_W-1], a};
    n = n >>> 1;
    return n[FX_W-1:0];
  endfunction

  function automatic fxr_t fx_spr(input fx_t speed, input fx_t speedx,
                                  input fx_t thr, input fx_t proj);
    fxr_t res;
    if (speed >= thr) begin
      res.ovf = 1'b0;
      res.v   = proj;
    end else begin
      res = fx_add(speedx, FX_ONE);
    end
    return res;
  endfunction

  function automatic fxr_t fx_spl(input fx_t speed, input fx_t speedx,
                                  input fx_t thr, input fx_t proj);
    fxr_t res;
    if (speed <= thr) begin
      res.ovf = 1'b0;
      res.v   = -proj;
    end else begin
      res = fx_sub(speedx, FX_ONE);
    end
    return res;
  endfunction

endpackage

>>> hdl/mhtc_div.sv
module mhtc_div
  import mhtc_pkg::*;
(
  input  logic clk,
  input  logic en,
  input  fx_t  dvd,
  input  fx_t  dvs,
  input  logic flag_en,
  output fx_t  q,
  output logic q_ovf
);

  typedef struct packed {
    logic [FX_W-1:0]      rem;
    logic [DIV_NUM_W-1:0] num;
    logic [FX_W-1:0]      dvs;
    logic                 neg;
    logic                 zero;
    logic                 pos;
    logic                 flg;
  } div_st_t;

  div_st_t st_r [DIV_STEPS+1];
  div_st_t prep_nxt;
  div_st_t step_nxt [DIV_STEPS];
  fx_t     q_nxt;
  logic    ovf_nxt;
  fx_t     q_r;
  logic    ovf_r;

  // Take magnitudes and signs
  always_comb begin
    logic [FX_W:0] am;
    logic [FX_W:0] bm;
    am = dvd[FX_W-1] ? -{dvd[FX_W-1], dvd} : {dvd[FX_W-1], dvd};
    bm = dvs[FX_W-1] ? -{dvs[FX_W-1], dvs} : {dvs[FX_W-1], dvs};
    prep_nxt.rem  = '0;
    prep_nxt.num  = {am[FX_W-1:0], 16'b0};
    prep_nxt.dvs  = bm[FX_W-1:0];
    prep_nxt.neg  = dvd[FX_W-1] ^ dvs[FX_W-1];
    prep_nxt.zero = (dvs == '0);
    prep_nxt.pos  = !dvd[FX_W-1];
    prep_nxt.flg  = flag_en;
  end

  // Restoring steps, a few quotient bits per stage
  always_comb begin
    for (int s = 0; s < DIV_STEPS; s++) begin
      div_st_t w;
      logic [FX_W:0] r2;
      w = st_r[s];
      for (int b = 0; b < DIV_BITS_STEP; b++) begin
        r2 = {w.rem, w.num[DIV_NUM_W-1]};
        if (r2 >= {1'b0, w.dvs}) begin
          r2    = r2 - {1'b0, w.dvs};
          w.num = {w.num[DIV_NUM_W-2:0], 1'b1};
        end else begin
          w.num = {w.num[DIV_NUM_W-2:0], 1'b0};
        end
        w.rem = r2[FX_W-1:0];
      end
      step_nxt[s] = w;
    end
  end

  // Sign and saturate the quotient
  always_comb begin
    div_st_t f;
    f = st_r[DIV_STEPS];
    if (f.zero) begin
      q_nxt   = f.pos ? FX_MAX : FX_MIN;
      ovf_nxt = f.flg;
    end else if (f.neg) begin
      if ((|f.num[DIV_NUM_W-1:FX_W]) || (f.num[FX_W-1] && (|f.num[FX_W-2:0]))) begin
        q_nxt   = FX_MIN;
        ovf_nxt = f.flg;
      end else begin
        q_nxt   = -fx_t'(f.num[FX_W-1:0]);
        ovf_nxt = 1'b0;
      end
    end else if (|f.num[DIV_NUM_W-1:FX_W-1]) begin
      q_nxt   = FX_MAX;
      ovf_nxt = f.flg;
    end else begin
      q_nxt   = fx_t'(f.num[FX_W-1:0]);
      ovf_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      st_r[0] <= prep_nxt;
      for (int s = 0; s < DIV_STEPS; s++) st_r[s+1] <= step_nxt[s];
      q_r   <= q_nxt;
      ovf_r <= ovf_nxt;
    end
  end

  assign q     = q_r;
  assign q_ovf = ovf_r;

endmodule

>>> hdl/muscl_hancock_trace_cell_top.sv
// Characteristic tracing for one cell of a 2D Euler sweep in Q16.16. Each
// transfer on the input channel carries one cell's primitive state, sound
// speed, limited slopes and a passive scalar; each transfer on the output
// channel carries the predicted right-face and left-face states and a flag
// that is set when any step but the threshold saturated or a cell divisor was
// zero. The pipeline takes one cell per clock unless stalled and returns
// results in order via two stages of products, a 24-stage radix-4 divider for
// the four quotients (the MUSCL threshold 100/dt_over_dx runs through its own
// copy alongside each cell), then five stages of projection arithmetic and
// the output register. A finished result held by out_stall freezes the whole
// pipeline, which in turn raises in_stall. Configuration writes are accepted
// at any time (cfg_ready is tied high) but must only be made while no cell is
// in flight.
module muscl_hancock_trace_cell_top
  import mhtc_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  in_t         in_data,
  output logic        out_valid,
  input  logic        out_stall,
  output out_t        out_data,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  // Payload carried alongside the dividers
  typedef struct packed {
    logic vld;
    logic ovf;
    fx_t  r;
    fx_t  u;
    fx_t  v;
    fx_t  p;
    fx_t  dr;
    fx_t  du;
    fx_t  dv;
    fx_t  dp;
    fx_t  a;
    fx_t  da;
    fx_t  csq;
    fx_t  rc;
    fx_t  upc;
    fx_t  umc;
    fx_t  ux;
    fx_t  upcx;
    fx_t  umcx;
  } pl_t;

  typedef struct packed {
    logic      vld;
    logic      ovf;
    fx_t       r;
    fx_t       u;
    fx_t       v;
    fx_t       p;
    fx_t       a;
    fx_t       dv;
    fx_t       da;
    fx_t       csq;
    fx_t       cor;
    fx_t       roc;
    fx_t       h1;
    fx_t       h2;
    fx_t       a0r;
    fx_t [1:0] nspp;
    fx_t [1:0] nspm;
    fx_t [1:0] nsp0;
  } e1_t;

  typedef struct packed {
    logic      vld;
    logic      ovf;
    fx_t       r;
    fx_t       u;
    fx_t       v;
    fx_t       p;
    fx_t       a;
    fx_t       csq;
    fx_t       cor;
    fx_t       am;
    fx_t       ap;
    fx_t [1:0] nspp;
    fx_t [1:0] nspm;
    fx_t [1:0] zr;
    fx_t [1:0] zv;
    fx_t [1:0] zs;
  } e2_t;

  typedef struct packed {
    logic      vld;
    logic      ovf;
    fx_t       r;
    fx_t       u;
    fx_t       v;
    fx_t       p;
    fx_t       a;
    fx_t       csq;
    fx_t       cor;
    fx_t [1:0] pr;
    fx_t [1:0] mr;
    fx_t [1:0] zr;
    fx_t [1:0] zv;
    fx_t [1:0] zs;
  } e3_t;

  typedef struct packed {
    logic      vld;
    logic      ovf;
    fx_t       r;
    fx_t       u;
    fx_t       p;
    fx_t       csq;
    fx_t       cor;
    fx_t [1:0] s;
    fx_t [1:0] d;
    fx_t [1:0] q;
    fx_t [1:0] o2;
    fx_t [1:0] o4;
  } e4_t;

  typedef struct packed {
    logic      vld;
    logic      ovf;
    fx_t       u;
    fx_t       p;
    fx_t [1:0] o0;
    fx_t [1:0] o2;
    fx_t [1:0] o4;
    fx_t [1:0] m1;
    fx_t [1:0] m3;
  } e5_t;

  logic [30:0] dtdx_r;
  logic [1:0]  mode_r;
  fx_t         dtdx_s;
  logic        en;

  pl_t  s1_r, s1_nxt;
  pl_t  s2_nxt;
  pl_t  line_r [DIV_LAT];
  e1_t  e1_r, e1_nxt;
  e2_t  e2_r, e2_nxt;
  e3_t  e3_r, e3_nxt;
  e4_t  e4_r, e4_nxt;
  e5_t  e5_r, e5_nxt;
  out_t out_r, out_nxt;
  logic out_valid_r;

  fx_t  roc_q, cor_q, thr_q, dprc_q, dpcsq_q;
  logic roc_ovf, cor_ovf, thr_ovf, dprc_ovf, dpcsq_ovf;
  fx_t  roc_d_r, cor_d_r, thr_d_r;
  logic roc_ovf_d_r, cor_ovf_d_r;

  // Hold everything while a finished result waits
  assign en       = !(out_valid_r && out_stall);
  assign in_stall = !en;
  assign dtdx_s   = fx_t'({1'b0, dtdx_r});

  // Configuration registers
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dtdx_r <= 31'd6554;
      mode_r <= MODE_MUSCL;
    end else if (cfg_valid && cfg_ready && (cfg_index[1] == 1'b0)) begin
      unique case (cfg_index[0])
        CFG_DTDX: dtdx_r <= cfg_data[30:0];
        CFG_MODE: mode_r <= cfg_data[1:0];
      endcase
    end
  end

  // Stage 1: squares, products and wave speeds straight from the port
  always_comb begin
    fxr_t csq, rc, upc, umc, ux;
    csq = fx_mul(in_data.sound_speed, in_data.sound_speed);
    rc  = fx_mul(in_data.density, in_data.sound_speed);
    upc = fx_add(in_data.vel_normal, in_data.sound_speed);
    umc = fx_sub(in_data.vel_normal, in_data.sound_speed);
    ux  = fx_mul(in_data.vel_normal, dtdx_s);
    s1_nxt      = '0;
    s1_nxt.vld  = in_valid;
    s1_nxt.ovf  = csq.ovf | rc.ovf | upc.ovf | umc.ovf | ux.ovf;
    s1_nxt.r    = in_data.density;
    s1_nxt.u    = in_data.vel_normal;
    s1_nxt.v    = in_data.vel_trans;
    s1_nxt.p    = in_data.pressure;
    s1_nxt.dr   = in_data.slope_density;
    s1_nxt.du   = in_data.slope_vel_normal;
    s1_nxt.dv   = in_data.slope_vel_trans;
    s1_nxt.dp   = in_data.slope_pressure;
    s1_nxt.a    = in_data.scalar_value;
    s1_nxt.da   = in_data.scalar_slope;
    s1_nxt.csq  = csq.v;
    s1_nxt.rc   = rc.v;
    s1_nxt.upc  = upc.v;
    s1_nxt.umc  = umc.v;
    s1_nxt.ux   = ux.v;
  end

  // Quotients that need only the raw cell, plus the MUSCL threshold
  mhtc_div u_div_roc (
    .clk(clk), .en(en), .dvd(in_data.density), .dvs(in_data.sound_speed),
    .flag_en(1'b1), .q(roc_q), .q_ovf(roc_ovf)
  );

  mhtc_div u_div_cor (
    .clk(clk), .en(en), .dvd(in_data.sound_speed), .dvs(in_data.density),
    .flag_en(1'b1), .q(cor_q), .q_ovf(cor_ovf)
  );

  // The threshold saturates silently
  mhtc_div u_div_thr (
    .clk(clk), .en(en), .dvd(FX_HUNDRED), .dvs(dtdx_s),
    .flag_en(1'b0), .q(thr_q), .q_ovf(thr_ovf)
  );

  // Quotients that need the stage-1 products, fed from the stage-1 register
  mhtc_div u_div_dprc (
    .clk(clk), .en(en), .dvd(s1_r.dp), .dvs(s1_r.rc),
    .flag_en(1'b1), .q(dprc_q), .q_ovf(dprc_ovf)
  );

  mhtc_div u_div_dpcsq (
    .clk(clk), .en(en), .dvd(s1_r.dp), .dvs(s1_r.csq),
    .flag_en(1'b1), .q(dpcsq_q), .q_ovf(dpcsq_ovf)
  );

  // Stage 2: scaled wave speeds
  always_comb begin
    fxr_t upcx, umcx;
    upcx = fx_mul(s1_r.upc, dtdx_s);
    umcx = fx_mul(s1_r.umc, dtdx_s);
    s2_nxt      = s1_r;
    s2_nxt.ovf  = s1_r.ovf | upcx.ovf | umcx.ovf;
    s2_nxt.upcx = upcx.v;
    s2_nxt.umcx = umcx.v;
  end

  // E1: wave amplitude terms and upwind projection factors
  always_comb begin
    pl_t  l;
    fxr_t t1, t2, a0r;
    fxr_t spp, spm, sp0;
    fx_t  thr_rt, thr_lt, proj;
    logic ovf;
    l      = line_r[DIV_LAT-1];
    t1     = fx_sub(dprc_q, l.du);
    t2     = fx_add(dprc_q, l.du);
    a0r    = fx_sub(l.dr, dpcsq_q);
    thr_rt = (mode_r == MODE_MUSCL) ? thr_d_r : '0;
    thr_lt = -thr_rt;
    proj   = ((mode_r == MODE_MUSCL) || (mode_r == MODE_PLMDE)) ? FX_ONE : '0;
    ovf    = l.ovf | dprc_ovf | dpcsq_ovf | roc_ovf_d_r | cor_ovf_d_r
           | t1.ovf | t2.ovf | a0r.ovf;
    e1_nxt.vld = l.vld;
    e1_nxt.r   = l.r;
    e1_nxt.u   = l.u;
    e1_nxt.v   = l.v;
    e1_nxt.p   = l.p;
    e1_nxt.a   = l.a;
    e1_nxt.dv  = l.dv;
    e1_nxt.da  = l.da;
    e1_nxt.csq = l.csq;
    e1_nxt.cor = cor_d_r;
    e1_nxt.roc = roc_d_r;
    e1_nxt.h1  = fx_half(t1.v);
    e1_nxt.h2  = fx_half(t2.v);
    e1_nxt.a0r = a0r.v;
    // Right face first, then left face
    for (int k = 0; k < 2; k++) begin
      if (k == 0) begin
        spm = fx_spr(l.umc, l.umcx, thr_rt, proj);
        spp = fx_spr(l.upc, l.upcx, thr_rt, proj);
        sp0 = fx_spr(l.u, l.ux, thr_rt, proj);
      end else begin
        spm = fx_spl(l.umc, l.umcx, thr_lt, proj);
        spp = fx_spl(l.upc, l.upcx, thr_lt, proj);
        sp0 = fx_spl(l.u, l.ux, thr_lt, proj);
      end
      ovf = ovf | spm.ovf | spp.ovf | sp0.ovf;
      e1_nxt.nspp[k] = fx_negh(spp.v);
      e1_nxt.nspm[k] = fx_negh(spm.v);
      e1_nxt.nsp0[k] = fx_negh(sp0.v);
    end
    e1_nxt.ovf = ovf;
  end

  // E2: acoustic amplitudes and entropy, shear and scalar increments
  always_comb begin
    fxr_t am, ap, zr, zv, zs;
    logic ovf;
    am  = fx_mul(e1_r.h1, e1_r.roc);
    ap  = fx_mul(e1_r.h2, e1_r.roc);
    ovf = e1_r.ovf | am.ovf | ap.ovf;
    e2_nxt.vld  = e1_r.vld;
    e2_nxt.r    = e1_r.r;
    e2_nxt.u    = e1_r.u;
    e2_nxt.v    = e1_r.v;
    e2_nxt.p    = e1_r.p;
    e2_nxt.a    = e1_r.a;
    e2_nxt.csq  = e1_r.csq;
    e2_nxt.cor  = e1_r.cor;
    e2_nxt.am   = am.v;
    e2_nxt.ap   = ap.v;
    e2_nxt.nspp = e1_r.nspp;
    e2_nxt.nspm = e1_r.nspm;
    for (int k = 0; k < 2; k++) begin
      zr = fx_mul(e1_r.nsp0[k], e1_r.a0r);
      zv = fx_mul(e1_r.nsp0[k], e1_r.dv);
      zs = fx_mul(e1_r.nsp0[k], e1_r.da);
      ovf = ovf | zr.ovf | zv.ovf;
      if (NUM_VARS > 4) ovf = ovf | zs.ovf;
      e2_nxt.zr[k] = zr.v;
      e2_nxt.zv[k] = zv.v;
      e2_nxt.zs[k] = zs.v;
    end
    e2_nxt.ovf = ovf;
  end

  // E3: projected acoustic waves
  always_comb begin
    fxr_t pr, mr;
    logic ovf;
    ovf = e2_r.ovf;
    e3_nxt.vld = e2_r.vld;
    e3_nxt.r   = e2_r.r;
    e3_nxt.u   = e2_r.u;
    e3_nxt.v   = e2_r.v;
    e3_nxt.p   = e2_r.p;
    e3_nxt.a   = e2_r.a;
    e3_nxt.csq = e2_r.csq;
    e3_nxt.cor = e2_r.cor;
    e3_nxt.zr  = e2_r.zr;
    e3_nxt.zv  = e2_r.zv;
    e3_nxt.zs  = e2_r.zs;
    for (int k = 0; k < 2; k++) begin
      pr = fx_mul(e2_r.nspp[k], e2_r.ap);
      mr = fx_mul(e2_r.nspm[k], e2_r.am);
      ovf = ovf | pr.ovf | mr.ovf;
      e3_nxt.pr[k] = pr.v;
      e3_nxt.mr[k] = mr.v;
    end
    e3_nxt.ovf = ovf;
  end

  // E4: wave sums, transverse velocity and scalar faces
  always_comb begin
    fxr_t s, d, q, o2, o4;
    logic ovf;
    ovf = e3_r.ovf;
    e4_nxt.vld = e3_r.vld;
    e4_nxt.r   = e3_r.r;
    e4_nxt.u   = e3_r.u;
    e4_nxt.p   = e3_r.p;
    e4_nxt.csq = e3_r.csq;
    e4_nxt.cor = e3_r.cor;
    for (int k = 0; k < 2; k++) begin
      s  = fx_add(e3_r.pr[k], e3_r.mr[k]);
      d  = fx_sub(e3_r.pr[k], e3_r.mr[k]);
      q  = fx_add(s.v, e3_r.zr[k]);
      o2 = fx_add(e3_r.v, e3_r.zv[k]);
      o4 = fx_add(e3_r.a, e3_r.zs[k]);
      ovf = ovf | s.ovf | d.ovf | q.ovf | o2.ovf;
      e4_nxt.s[k]  = s.v;
      e4_nxt.d[k]  = d.v;
      e4_nxt.q[k]  = q.v;
      e4_nxt.o2[k] = o2.v;
      // Drop the scalar when it is not configured
      if (NUM_VARS > 4) begin
        ovf = ovf | o4.ovf;
        e4_nxt.o4[k] = o4.v;
      end else begin
        e4_nxt.o4[k] = '0;
      end
    end
    e4_nxt.ovf = ovf;
  end

  // E5: density face and the velocity and pressure increments
  always_comb begin
    fxr_t o0, m1, m3;
    logic ovf;
    ovf = e4_r.ovf;
    e5_nxt.vld = e4_r.vld;
    e5_nxt.u   = e4_r.u;
    e5_nxt.p   = e4_r.p;
    e5_nxt.o2  = e4_r.o2;
    e5_nxt.o4  = e4_r.o4;
    for (int k = 0; k < 2; k++) begin
      o0 = fx_add(e4_r.r, e4_r.q[k]);
      m1 = fx_mul(e4_r.d[k], e4_r.cor);
      m3 = fx_mul(e4_r.s[k], e4_r.csq);
      ovf = ovf | o0.ovf | m1.ovf | m3.ovf;
      e5_nxt.o0[k] = o0.v;
      e5_nxt.m1[k] = m1.v;
      e5_nxt.m3[k] = m3.v;
    end
    e5_nxt.ovf = ovf;
  end

  // Output stage: normal velocity and pressure faces
  always_comb begin
    fxr_t o1r, o3r, o1l, o3l;
    o1r = fx_add(e5_r.u, e5_r.m1[0]);
    o3r = fx_add(e5_r.p, e5_r.m3[0]);
    o1l = fx_add(e5_r.u, e5_r.m1[1]);
    o3l = fx_add(e5_r.p, e5_r.m3[1]);
    out_nxt.right_density    = e5_r.o0[0];
    out_nxt.right_vel_normal = o1r.v;
    out_nxt.right_vel_trans  = e5_r.o2[0];
    out_nxt.right_pressure   = o3r.v;
    out_nxt.right_scalar     = e5_r.o4[0];
    out_nxt.left_density     = e5_r.o0[1];
    out_nxt.left_vel_normal  = o1l.v;
    out_nxt.left_vel_trans   = e5_r.o2[1];
    out_nxt.left_pressure    = o3l.v;
    out_nxt.left_scalar      = e5_r.o4[1];
    out_nxt.overflow_flag    = e5_r.ovf | o1r.ovf | o3r.ovf | o1l.ovf | o3l.ovf;
  end

  // Payload registers advance together; only valid bits see reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_r.vld <= 1'b0;
      for (int i = 0; i < DIV_LAT; i++) line_r[i].vld <= 1'b0;
      e1_r.vld    <= 1'b0;
      e2_r.vld    <= 1'b0;
      e3_r.vld    <= 1'b0;
      e4_r.vld    <= 1'b0;
      e5_r.vld    <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      s1_r    <= s1_nxt;
      line_r[0] <= s2_nxt;
      for (int i = 1; i < DIV_LAT; i++) line_r[i] <= line_r[i-1];
      roc_d_r     <= roc_q;
      cor_d_r     <= cor_q;
      thr_d_r     <= thr_q;
      roc_ovf_d_r <= roc_ovf;
      cor_ovf_d_r <= cor_ovf;
      e1_r  <= e1_nxt;
      e2_r  <= e2_nxt;
      e3_r  <= e3_nxt;
      e4_r  <= e4_nxt;
      e5_r  <= e5_nxt;
      out_r <= out_nxt;
      out_valid_r <= e5_r.vld;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule
